>>> design/grid_neighbor_offset_enumerator_defines.svh
// Assertion macros shared by the grid neighbour enumerator.
// Each check is sampled on the rising edge of clk_i and is switched off during reset.
`ifndef GRID_NEIGHBOR_OFFSET_ENUMERATOR_DEFINES_SVH
`define GRID_NEIGHBOR_OFFSET_ENUMERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define GNOE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define GNOE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GNOE_ASSERT_SAME(lbl, ante, cons, msg)
`define GNOE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/gnoe_pkg.sv
package gnoe_pkg;

  localparam int unsigned CELL_W     = 20;
  localparam int unsigned SIDE_W     = 11;
  localparam int unsigned SQ_W       = 2 * SIDE_W;
  localparam int unsigned OFF_W      = 13;
  localparam int unsigned OFF_WIDE_W = 14;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned ICLS_W     = 4;
  localparam int unsigned OCLS_W     = 5;
  localparam int unsigned N_INNER    = 8;
  localparam int unsigned N_OUTER    = 16;
  localparam int unsigned N_SLOTS    = N_INNER + N_OUTER;
  localparam int unsigned SEL_W      = $clog2(N_SLOTS);
  localparam int unsigned CNT_W      = $clog2(CELL_W);

  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd256;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 11'd5;

  // Stream payload layout.
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 48;
  localparam int unsigned M_SLOT_LSB = 0;
  localparam int unsigned M_OFF_LSB  = M_SLOT_LSB + SLOT_W;
  localparam int unsigned M_NBR_LSB  = M_OFF_LSB + OFF_W;
  localparam int unsigned M_ICLS_LSB = M_NBR_LSB + CELL_W;
  localparam int unsigned M_OCLS_LSB = M_ICLS_LSB + ICLS_W;
  localparam int unsigned M_PAD_LSB  = M_OCLS_LSB + OCLS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLASS,
    ST_EMIT
  } state_e;

  // Position class of a row or a column within the grid.
  typedef enum logic [2:0] {
    CLS_FIRST,
    CLS_SECOND,
    CLS_MIDDLE,
    CLS_PENULT,
    CLS_LAST
  } cls_e;

  typedef struct packed {
    logic load;
    logic step;
    logic classify;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
    logic pend_last;
  } status_t;

  localparam logic [N_INNER-1:0] INNER_MASK [9] = '{
    8'hD0, 8'hF8, 8'h68,
    8'hD6, 8'hFF, 8'h6B,
    8'h16, 8'h1F, 8'h0B
  };

  localparam logic [N_OUTER-1:0] OUTER_MASK [25] = '{
    16'hE500, 16'hF500, 16'hFF80, 16'h7A80, 16'h3A80,
    16'hE540, 16'hF540, 16'hFFE0, 16'h7AA0, 16'h3AA0,
    16'hE55C, 16'hF55E, 16'hFFFF, 16'h7AAF, 16'h3AA7,
    16'h055C, 16'h055E, 16'h07FF, 16'h02AF, 16'h02A7,
    16'h015C, 16'h015E, 16'h01FF, 16'h00AF, 16'h00A7
  };

  // Row and column steps of every slot: the eight inner slots, then the sixteen outer ones.
  localparam logic signed [2:0] SLOT_DY [N_SLOTS] = '{
    -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1,
    -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd1, -3'sd1, 3'sd0,
    3'sd0, 3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2
  };

  localparam logic signed [2:0] SLOT_DX [N_SLOTS] = '{
    -3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd0, 3'sd1,
    -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd2, 3'sd2, -3'sd2,
    3'sd2, -3'sd2, 3'sd2, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2
  };

endpackage

>>> design/gnoe_ctrl.sv
module gnoe_ctrl import gnoe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  input  status_t status_i,
  output logic    s_ready_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_CLASS;
      end
      ST_CLASS: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.pend_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o   = 1'b1;
        cmd_o.load  = s_valid_i;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
      end
      ST_CLASS: begin
        cmd_o.classify = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> design/gnoe_dp.sv
module gnoe_dp import gnoe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [SIDE_W-1:0]        side_i,
  input  logic [CELL_W-1:0]        cell_i,
  input  logic                     m_ready_i,
  output status_t                  status_o,
  output logic                     m_valid_o,
  output logic                     ring_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic signed [OFF_W-1:0]  offset_o,
  output logic [CELL_W-1:0]        nbr_o,
  output logic [ICLS_W-1:0]        icls_o,
  output logic [OCLS_W-1:0]        ocls_o,
  output logic                     last_o
);

  logic [CELL_W-1:0]  center_q;
  logic [CELL_W-1:0]  div_q;
  logic [SIDE_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [SQ_W-1:0]    sq_q;
  logic [N_SLOTS-1:0] pend_q;
  logic [ICLS_W-1:0]  icls_q, icls_d;
  logic [OCLS_W-1:0]  ocls_q, ocls_d;

  logic                     out_valid_q;
  logic                     out_ring_q, out_last_q;
  logic [SLOT_W-1:0]        out_slot_q;
  logic signed [OFF_W-1:0]  out_off_q;
  logic [CELL_W-1:0]        out_nbr_q;
  logic [ICLS_W-1:0]        out_icls_q;
  logic [OCLS_W-1:0]        out_ocls_q;

  // Restoring remainder step: one dividend bit per cycle, most significant first.
  logic [SIDE_W:0] trial, trial_diff;
  logic            trial_ge;

  assign trial      = {rem_q, div_q[CELL_W-1]};
  assign trial_ge   = trial >= {1'b0, side_i};
  assign trial_diff = trial - {1'b0, side_i};
  assign rem_d      = trial_ge ? trial_diff[SIDE_W-1:0] : trial[SIDE_W-1:0];

  // Row and column classification once the remainder is known.
  logic [SQ_W-1:0]   center_w, side_w, side2_w, last_start, pen_start;
  logic [SIDE_W-1:0] side_m1, side_m2;
  cls_e              row_cls, col_cls;
  logic [1:0]        row_cls1, col_cls1;

  assign center_w   = SQ_W'(center_q);
  assign side_w     = SQ_W'(side_i);
  assign side2_w    = SQ_W'({side_i, 1'b0});
  assign last_start = sq_q - side_w;
  assign pen_start  = sq_q - side2_w;
  assign side_m1    = side_i - SIDE_W'(1);
  assign side_m2    = side_i - SIDE_W'(2);

  always_comb begin
    priority if (center_w < side_w) begin
      row_cls = CLS_FIRST;
    end else if (center_w < side2_w) begin
      row_cls = CLS_SECOND;
    end else if (center_w >= last_start) begin
      row_cls = CLS_LAST;
    end else if (center_w >= pen_start) begin
      row_cls = CLS_PENULT;
    end else begin
      row_cls = CLS_MIDDLE;
    end

    priority if (rem_q == '0) begin
      col_cls = CLS_FIRST;
    end else if (rem_q == SIDE_W'(1)) begin
      col_cls = CLS_SECOND;
    end else if (rem_q == side_m2) begin
      col_cls = CLS_PENULT;
    end else if (rem_q == side_m1) begin
      col_cls = CLS_LAST;
    end else begin
      col_cls = CLS_MIDDLE;
    end

    // The inner ring only knows first, inner and last.
    row_cls1 = (row_cls == CLS_FIRST) ? 2'd0 : ((row_cls == CLS_LAST) ? 2'd2 : 2'd1);
    col_cls1 = (col_cls == CLS_FIRST) ? 2'd0 : ((col_cls == CLS_LAST) ? 2'd2 : 2'd1);
    icls_d   = ICLS_W'(row_cls1) * ICLS_W'(3) + ICLS_W'(col_cls1);
    ocls_d   = OCLS_W'(row_cls) * OCLS_W'(5) + OCLS_W'(col_cls);
  end

  // Pick the lowest pending slot and form its offset.
  logic [SEL_W-1:0]              sel;
  logic [SEL_W-1:0]              sel_outer;
  logic [N_SLOTS-1:0]            pend_rest;
  logic                          sel_ring;
  logic signed [OFF_WIDE_W-1:0]  dy_w, dx_w, s_w, off_wide;

  always_comb begin
    sel = '0;
    for (int i = N_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) sel = SEL_W'(i);
    end
  end

  assign pend_rest = pend_q & (pend_q - N_SLOTS'(1));
  assign sel_ring  = sel >= SEL_W'(N_INNER);
  assign sel_outer = sel - SEL_W'(N_INNER);
  assign dy_w      = OFF_WIDE_W'(SLOT_DY[sel]);
  assign dx_w      = OFF_WIDE_W'(SLOT_DX[sel]);
  assign s_w       = signed'(OFF_WIDE_W'(side_i));
  assign off_wide  = dy_w * s_w + dx_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if (cmd_i.classify) begin
        pend_q <= {OUTER_MASK[ocls_d], INNER_MASK[icls_d]};
      end else if (cmd_i.emit) begin
        pend_q <= pend_rest;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      center_q <= cell_i;
      div_q    <= cell_i;
      rem_q    <= '0;
      sq_q     <= side_w * side_w;
    end else if (cmd_i.step) begin
      div_q <= div_q << 1;
      rem_q <= rem_d;
    end

    if (cmd_i.classify) begin
      icls_q <= icls_d;
      ocls_q <= ocls_d;
    end

    if (cmd_i.emit) begin
      out_ring_q <= sel_ring;
      out_slot_q <= sel_ring ? SLOT_W'(sel_outer) : SLOT_W'(sel);
      out_off_q  <= off_wide[OFF_W-1:0];
      out_nbr_q  <= center_q + CELL_W'(off_wide);
      out_icls_q <= icls_q;
      out_ocls_q <= ocls_q;
      out_last_q <= pend_rest == '0;
    end
  end

  assign status_o.div_last  = cnt_q == CNT_W'(CELL_W - 1);
  assign status_o.out_free  = !out_valid_q || m_ready_i;
  assign status_o.pend_last = pend_rest == '0;

  assign m_valid_o = out_valid_q;
  assign ring_o    = out_ring_q;
  assign slot_o    = out_slot_q;
  assign offset_o  = out_off_q;
  assign nbr_o     = out_nbr_q;
  assign icls_o    = out_icls_q;
  assign ocls_o    = out_ocls_q;
  assign last_o    = out_last_q;

endmodule

>>> design/grid_neighbor_offset_enumerator.sv
// Channel        Direction  Beat contents
// cfg_we_i       in         cfg_wdata_i: grid_side
// s_axis         in         tdata: cell_index
// m_axis         out        tuser: ring; tdata: slot, offset, neighbor_index, inner_class,
//                           outer_class; tlast: last
//
// A cell is accepted, its column remainder is formed in the bit-serial divider, it is
// classified, then one result (8 to 24) is emitted per cycle while the output is not stalled.
// The output register frees the next accept.
// Reset clears the controller and output valid, and sets grid_side to 256.
// A stalled output holds the current beat and pauses the emission of further results.
`include "grid_neighbor_offset_enumerator_defines.svh"

module grid_neighbor_offset_enumerator import gnoe_pkg::*; #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SIDE_W-1:0]    cfg_wdata_i,     // grid_side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,    // [19:0] cell_index
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [3:0] slot, [16:4] offset, [36:17] neighbor_index, [40:37] inner_class,
  // [45:41] outer_class, [47:46] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,    // [0] ring
  output logic                 m_axis_tlast
);

  localparam logic [SIDE_W+1:0] MaxSide = (SIDE_W + 2)'(MAX_SIDE);

  logic [SIDE_W-1:0] side_q;
  logic [SIDE_W-1:0] side_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // Saturate the side into the supported range.
  always_comb begin
    priority if (side_q < SIDE_MIN) begin
      side_eff = SIDE_MIN;
    end else if ({2'b00, side_q} > MaxSide) begin
      side_eff = MaxSide[SIDE_W-1:0];
    end else begin
      side_eff = side_q;
    end
  end

  cmd_t    cmd;
  status_t status;

  logic                    ring;
  logic [SLOT_W-1:0]       slot;
  logic signed [OFF_W-1:0] offset;
  logic [CELL_W-1:0]       nbr;
  logic [ICLS_W-1:0]       icls;
  logic [OCLS_W-1:0]       ocls;

  gnoe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  gnoe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .side_i    (side_eff),
    .cell_i    (s_axis_tdata[CELL_W-1:0]),
    .m_ready_i (m_axis_tready),
    .status_o  (status),
    .m_valid_o (m_axis_tvalid),
    .ring_o    (ring),
    .slot_o    (slot),
    .offset_o  (offset),
    .nbr_o     (nbr),
    .icls_o    (icls),
    .ocls_o    (ocls),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tuser = ring;
  assign m_axis_tdata = {(M_TDATA_W - M_PAD_LSB)'(0), ocls, icls, nbr, offset, slot};

  `GNOE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a cell was still in progress")
  `GNOE_ASSERT_SAME(a_frame_open_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "ready for a new cell before its last result was formed")
  `GNOE_ASSERT_SAME(a_class_range, m_axis_tvalid, (icls <= ICLS_W'(8)) && (ocls <= OCLS_W'(24)), "boundary class out of range")
  `GNOE_ASSERT_SAME(a_inner_slot, m_axis_tvalid && !m_axis_tuser, slot < SLOT_W'(N_INNER), "inner ring result with an outer slot number")

endmodule
